[rtl/efc_pkg.sv]
// Package for the event frame checker: phase and status codes, mark words
// and fixed layout constants. No dependencies.
`default_nettype none

package efc_pkg;

  localparam int unsigned WORD_BYTES         = 4;
  localparam int unsigned EVENT_HEADER_WORDS = 4;
  localparam int unsigned BOARD_HEADER_WORDS = 3;
  localparam int unsigned EVENT_SIZE_POS     = 2;
  localparam int unsigned EVENT_NBOARDS_POS  = EVENT_HEADER_WORDS - 1;
  localparam int unsigned BOARD_MIN_BYTES    = (BOARD_HEADER_WORDS + 1) * WORD_BYTES;

  localparam logic [31:0] MARK_EVTH = 32'h4854_5645;
  localparam logic [31:0] MARK_EVNT = 32'h544E_5645;
  localparam logic [31:0] MARK_BRDH = 32'h4844_5242;
  localparam logic [31:0] MARK_BRDT = 32'h5444_5242;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_EVHEAD  = 3'd1,
    PH_BRDMARK = 3'd2,
    PH_BRDID   = 3'd3,
    PH_BRDSIZE = 3'd4,
    PH_BRDBODY = 3'd5,
    PH_EVTRAIL = 3'd6,
    PH_SKIP    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_EVT_MARK  = 3'd1,
    ST_TRUNCATED     = 3'd2,
    ST_BAD_BRD_MARK  = 3'd3,
    ST_BAD_BRD_SIZE  = 3'd4,
    ST_BAD_BRD_TRAIL = 3'd5,
    ST_BAD_EVT_TRAIL = 3'd6,
    ST_SIZE_MISMATCH = 3'd7
  } status_t;

endpackage

`default_nettype wire

[rtl/event_frame_checker.sv]
// Event frame checker: walks 32-bit words of back-to-back acquisition events
// and emits one verdict per event. Depends on efc_pkg.
//
// One word per cycle unless the output stalls. A word is taken into an input
// register, checked against the frame state by compare-and-count logic, and its
// verdict (if any) is registered in a result register as the word moves on. The
// input side stalls only while the result register holds a verdict that has not
// been taken and the staged word must move on. After an error, words are dropped
// without a verdict up to and including the next word with tlast set.
`default_nettype none

module event_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] stream_word
  input  wire logic        s_tlast,   // buffer_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] event_bytes, [63:32] boards_seen
  output logic [2:0]       m_tuser    // [2:0] status
);

  // input register
  logic        in_valid;
  logic [31:0] in_word;
  logic        in_end;
  logic        advance;

  // frame state
  efc_pkg::phase_t phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [31:0] boards_left, boards_left_next;
  logic [29:0] board_index, board_index_next;
  logic [29:0] board_length_words, board_length_words_next;
  logic [31:0] bytes_so_far, bytes_so_far_next;
  logic [31:0] declared_bytes, declared_bytes_next;
  logic [31:0] boards_done, boards_done_next;

  // check results
  logic            err;
  efc_pkg::status_t err_code;
  logic            done;
  logic            board_last;
  logic [31:0]     bytes_inc;
  logic            res_valid;
  efc_pkg::status_t res_status;
  logic [31:0]     res_bytes;

  // result register
  logic            out_valid;
  efc_pkg::status_t out_status;
  logic [31:0]     out_bytes;
  logic [31:0]     out_boards;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  assign bytes_inc  = (phase == efc_pkg::PH_IDLE) ? 32'(efc_pkg::WORD_BYTES)
                                                  : bytes_so_far + 32'(efc_pkg::WORD_BYTES);
  assign board_last = ({1'b0, board_index} + 31'd1) >= {1'b0, board_length_words};

  // word check
  always_comb begin
    err      = 1'b0;
    err_code = efc_pkg::ST_OK;
    done     = 1'b0;
    unique case (phase)
      efc_pkg::PH_IDLE: begin
        if (in_word != efc_pkg::MARK_EVTH) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_BAD_EVT_MARK;
        end
      end
      efc_pkg::PH_BRDMARK: begin
        if (in_word != efc_pkg::MARK_BRDH) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_BAD_BRD_MARK;
        end
      end
      efc_pkg::PH_BRDSIZE: begin
        if (in_word[1:0] != 2'd0 || in_word < 32'(efc_pkg::BOARD_MIN_BYTES)) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_BAD_BRD_SIZE;
        end
      end
      efc_pkg::PH_BRDBODY: begin
        if (board_last && in_word != efc_pkg::MARK_BRDT) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_BAD_BRD_TRAIL;
        end
      end
      efc_pkg::PH_EVTRAIL: begin
        if (in_word != efc_pkg::MARK_EVNT) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_BAD_EVT_TRAIL;
        end else if (bytes_inc != declared_bytes) begin
          err      = 1'b1;
          err_code = efc_pkg::ST_SIZE_MISMATCH;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (advance) begin
      if (phase == efc_pkg::PH_SKIP) begin
        if (in_end) phase_next = efc_pkg::PH_IDLE;
      end else if (err) begin
        phase_next = in_end ? efc_pkg::PH_IDLE : efc_pkg::PH_SKIP;
      end else if (done || in_end) begin
        phase_next = efc_pkg::PH_IDLE;
      end else begin
        unique case (phase)
          efc_pkg::PH_IDLE:    phase_next = efc_pkg::PH_EVHEAD;
          efc_pkg::PH_EVHEAD: begin
            if (header_index == 2'(efc_pkg::EVENT_NBOARDS_POS)) begin
              phase_next = (in_word != 32'd0) ? efc_pkg::PH_BRDMARK : efc_pkg::PH_EVTRAIL;
            end
          end
          efc_pkg::PH_BRDMARK: phase_next = efc_pkg::PH_BRDID;
          efc_pkg::PH_BRDID:   phase_next = efc_pkg::PH_BRDSIZE;
          efc_pkg::PH_BRDSIZE: phase_next = efc_pkg::PH_BRDBODY;
          efc_pkg::PH_BRDBODY: begin
            if (board_last) begin
              phase_next = (boards_left != 32'd1) ? efc_pkg::PH_BRDMARK
                                                  : efc_pkg::PH_EVTRAIL;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // counters and verdict
  always_comb begin
    header_index_next       = header_index;
    boards_left_next        = boards_left;
    board_index_next        = board_index;
    board_length_words_next = board_length_words;
    bytes_so_far_next       = bytes_so_far;
    declared_bytes_next     = declared_bytes;
    boards_done_next        = boards_done;
    res_valid               = 1'b0;
    res_status              = efc_pkg::ST_OK;
    res_bytes               = 32'd0;
    if (advance && phase != efc_pkg::PH_SKIP) begin
      bytes_so_far_next = bytes_inc;
      unique case (phase)
        efc_pkg::PH_IDLE: begin
          boards_done_next = 32'd0;
          if (!err) header_index_next = 2'd1;
        end
        efc_pkg::PH_EVHEAD: begin
          if (header_index == 2'(efc_pkg::EVENT_SIZE_POS)) declared_bytes_next = in_word;
          if (header_index == 2'(efc_pkg::EVENT_NBOARDS_POS)) begin
            boards_left_next  = in_word;
            header_index_next = 2'd0;
          end else begin
            header_index_next = header_index + 2'd1;
          end
        end
        efc_pkg::PH_BRDSIZE: begin
          if (!err) begin
            board_length_words_next = in_word[31:2];
            board_index_next        = 30'(efc_pkg::BOARD_HEADER_WORDS);
          end
        end
        efc_pkg::PH_BRDBODY: begin
          if (!board_last) begin
            board_index_next = board_index + 30'd1;
          end else if (!err) begin
            boards_done_next = boards_done + 32'd1;
            boards_left_next = boards_left - 32'd1;
          end
        end
        default: begin
        end
      endcase
      if (err) begin
        res_valid  = 1'b1;
        res_status = err_code;
      end else if (done) begin
        res_valid  = 1'b1;
        res_bytes  = bytes_inc;
      end else if (in_end) begin
        res_valid  = 1'b1;
        res_status = efc_pkg::ST_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= efc_pkg::PH_IDLE;
      header_index       <= 2'd0;
      boards_left        <= 32'd0;
      board_index        <= 30'd0;
      board_length_words <= 30'd0;
      bytes_so_far       <= 32'd0;
      declared_bytes     <= 32'd0;
      boards_done        <= 32'd0;
    end else begin
      phase              <= phase_next;
      header_index       <= header_index_next;
      boards_left        <= boards_left_next;
      board_index        <= board_index_next;
      board_length_words <= board_length_words_next;
      bytes_so_far       <= bytes_so_far_next;
      declared_bytes     <= declared_bytes_next;
      boards_done        <= boards_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= res_valid;
    end
    if (res_valid) begin
      out_status <= res_status;
      out_bytes  <= res_bytes;
      out_boards <= boards_done_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_boards, out_bytes};
  assign m_tuser  = out_status;

endmodule

`default_nettype wire
